// File: sv/rtpadts_pkg.sv
// Shared types, constants and the ADTS header builder for the RTP AAC to ADTS framer.
// No dependencies; used by rtpadts_ctrl, rtpadts_dp and rtp_aac_to_adts_framer.
package rtpadts_pkg;

  // Most access units stored and framed per packet
  localparam int MaxUnits = 15;
  localparam logic [3:0] MaxUnitsC = 4'(MaxUnits);

  localparam int SizeW = 13;
  localparam int PosW  = 16;

  // Reset value of the AudioSpecificConfig register
  localparam logic [15:0] AscReset = 16'h1210;

  // Configuration register index
  localparam logic RegAsc = 1'b0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAY,
    ST_FRAME
  } state_t;

  // What an accepted byte does
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PAY,
    ACT_FRAME
  } act_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic emit_pay;  // load a payload result
    logic pay_held;  // payload byte comes from the hold register
    logic emit_hdr;  // load the header result of the unit under the cursor
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_t act;          // action of the byte on the input
    logic can_load;     // output register free or draining
    logic pay_to_frame; // this payload byte ends its unit and more units follow
    logic hdr_last;     // current header closes the run
  } sts_t;

  // Build the 7-byte ADTS header for one access unit
  function automatic logic [55:0] adts_word(input logic [15:0] asc, input logic [SizeW-1:0] size);
    logic [7:0] a0;
    logic [7:0] a1;
    logic [12:0] fl;
    logic [1:0] prof;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    a0 = asc[15:8];
    a1 = asc[7:0];
    fl = size + 13'd7;
    prof = a0[4:3] - 2'd1;
    b2 = {prof, a0[2:0], a1[7], 1'b0, a1[5]};
    b3 = {a1[4:3], 4'b0000, fl[12:11]};
    b4 = fl[10:3];
    b5 = {fl[2:0], 5'h1F};
    return {8'hFF, 8'hF1, b2, b3, b4, b5, 8'hFC};
  endfunction

endpackage

// File: sv/rtpadts_ctrl.sv
// Sequencer of the RTP AAC to ADTS framer: input handshake and result ordering.
// Depends on rtpadts_pkg; drives rtpadts_dp through cmd_t, watches sts_t.
module rtpadts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rtpadts_pkg::sts_t   sts,
  output rtpadts_pkg::cmd_t   cmd
);

  rtpadts_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtpadts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      rtpadts_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          unique case (sts.act)
            rtpadts_pkg::ACT_PAY: begin
              if (sts.can_load) begin
                cmd.emit_pay = 1'b1;
                if (sts.pay_to_frame) state_nxt = rtpadts_pkg::ST_FRAME;
              end else begin
                state_nxt = rtpadts_pkg::ST_PAY;
              end
            end
            rtpadts_pkg::ACT_FRAME: state_nxt = rtpadts_pkg::ST_FRAME;
            default: state_nxt = rtpadts_pkg::ST_IDLE;
          endcase
        end
      end
      rtpadts_pkg::ST_PAY: begin
        // wait for the output slot, then send the held byte
        if (sts.can_load) begin
          cmd.emit_pay = 1'b1;
          cmd.pay_held = 1'b1;
          state_nxt = sts.pay_to_frame ? rtpadts_pkg::ST_FRAME : rtpadts_pkg::ST_IDLE;
        end
      end
      rtpadts_pkg::ST_FRAME: begin
        // one header per free output slot
        if (sts.can_load) begin
          cmd.emit_hdr = 1'b1;
          if (sts.hdr_last) state_nxt = rtpadts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtpadts_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/rtpadts_dp.sv
// Datapath of the RTP AAC to ADTS framer: packet position, size table, unit cursor,
// header build and output register. Depends on rtpadts_pkg; driven by rtpadts_ctrl.
module rtpadts_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rtpadts_pkg::cmd_t   cmd,
  output rtpadts_pkg::sts_t   sts,
  input  logic [7:0]          in_byte,
  input  logic                in_eop,
  input  logic [15:0]         asc_word,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  logic [rtpadts_pkg::PosW-1:0]  pos_r;
  logic [3:0]                    count_r;
  logic [7:0]                    hh_r;
  logic [rtpadts_pkg::SizeW-1:0] tbl_r [rtpadts_pkg::MaxUnits];
  logic [3:0]                    cur_r, cur_nxt;
  logic [rtpadts_pkg::SizeW-1:0] left_r, left_nxt;
  logic [3:0]                    u_r, u_nxt;
  logic                          eop_r;
  logic [7:0]                    pay_r;

  logic                          out_valid_r;
  logic                          out_hdr_r;
  logic [55:0]                   out_word_r;
  logic [7:0]                    out_byte_r;
  logic                          out_last_r;

  logic [5:0]                    hdr_end;
  logic [5:0]                    p_lo;
  logic [5:0]                    ofs;
  logic [3:0]                    idx;
  logic                          pos_ge14;
  logic                          pos_is13;
  logic                          in_hdr;
  logic                          frame_go;
  logic                          pay_go;
  logic [3:0]                    used;
  logic [4:0]                    cur_inc;
  logic [4:0]                    u_inc;
  logic [rtpadts_pkg::SizeW-1:0] size;
  logic                          eop_eff;
  logic [7:0]                    pay_byte;

  // Decode the byte position
  assign used     = (count_r > rtpadts_pkg::MaxUnitsC) ? rtpadts_pkg::MaxUnitsC : count_r;
  assign hdr_end  = 6'd14 + {1'b0, count_r, 1'b0};
  assign p_lo     = pos_r[5:0];
  assign ofs      = p_lo - 6'd14;
  assign idx      = ofs[4:1];
  assign pos_ge14 = pos_r >= 16'd14;
  assign pos_is13 = pos_r == 16'd13;
  assign in_hdr   = pos_ge14 && (pos_r < {10'd0, hdr_end});
  assign frame_go = in_hdr && pos_r[0] && ((p_lo + 6'd1) == hdr_end);
  assign pay_go   = pos_ge14 && !in_hdr && (cur_r < used) && (left_r != '0);

  assign cur_inc = {1'b0, cur_r} + 5'd1;
  assign u_inc   = {1'b0, u_r} + 5'd1;
  assign size    = tbl_r[u_r];
  assign eop_eff = cmd.take ? in_eop : eop_r;
  assign pay_byte = cmd.pay_held ? pay_r : in_byte;

  // Status to the controller
  always_comb begin
    if (frame_go) begin
      sts.act = rtpadts_pkg::ACT_FRAME;
    end else if (pay_go) begin
      sts.act = rtpadts_pkg::ACT_PAY;
    end else begin
      sts.act = rtpadts_pkg::ACT_NONE;
    end
    sts.can_load     = !out_valid_r || out_tready;
    sts.pay_to_frame = (left_r == 13'd1) && (cur_inc < {1'b0, used});
    sts.hdr_last     = (size != '0) || (u_inc >= {1'b0, used});
  end

  // Unit cursor and byte countdown
  always_comb begin
    cur_nxt  = cur_r;
    left_nxt = left_r;
    u_nxt    = u_r;
    if (cmd.take) begin
      if (pos_is13) begin
        cur_nxt  = '0;
        left_nxt = '0;
      end
      if (sts.act == rtpadts_pkg::ACT_FRAME) u_nxt = '0;
      if (in_eop && sts.act == rtpadts_pkg::ACT_NONE) begin
        cur_nxt  = '0;
        left_nxt = '0;
      end
    end
    if (cmd.emit_pay) begin
      left_nxt = left_r - 13'd1;
      if (left_r == 13'd1) begin
        if (sts.pay_to_frame) begin
          u_nxt = cur_inc[3:0];
        end else begin
          cur_nxt = used;
        end
      end
      if (!sts.pay_to_frame && eop_eff) begin
        cur_nxt  = '0;
        left_nxt = '0;
      end
    end
    if (cmd.emit_hdr) begin
      if (size != '0) begin
        cur_nxt  = u_r;
        left_nxt = size;
      end else if (sts.hdr_last) begin
        cur_nxt  = used;
        left_nxt = '0;
      end else begin
        u_nxt = u_inc[3:0];
      end
      if (sts.hdr_last && eop_r) begin
        cur_nxt  = '0;
        left_nxt = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      hh_r    <= '0;
      cur_r   <= '0;
      left_r  <= '0;
      u_r     <= '0;
      eop_r   <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      left_r <= left_nxt;
      u_r    <= u_nxt;
      if (cmd.take) begin
        eop_r <= in_eop;
        if (in_eop) begin
          pos_r <= '0;
        end else if (pos_r != 16'hFFFF) begin
          pos_r <= pos_r + 16'd1;
        end
        if (pos_is13) count_r <= in_byte[7:4];
        if (in_hdr && !pos_r[0]) hh_r <= in_byte;
      end
    end
  end

  // Size table and held payload byte
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pay_r <= in_byte;
      if (in_hdr && pos_r[0] && (idx < rtpadts_pkg::MaxUnitsC)) begin
        tbl_r[idx] <= {hh_r, in_byte[7:3]};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pay || cmd.emit_hdr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pay) begin
      out_hdr_r  <= 1'b0;
      out_word_r <= '0;
      out_byte_r <= pay_byte;
      out_last_r <= !sts.pay_to_frame;
    end else if (cmd.emit_hdr) begin
      out_hdr_r  <= 1'b1;
      out_word_r <= rtpadts_pkg::adts_word(asc_word, size);
      out_byte_r <= '0;
      out_last_r <= sts.hdr_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_byte_r, out_word_r};
  assign out_tuser  = out_hdr_r;
  assign out_tlast  = out_last_r;

endmodule

// File: sv/rtp_aac_to_adts_framer.sv
// Top level of the RTP AAC (hbr mode) to ADTS framer: config register, controller, datapath.
// Depends on rtpadts_pkg, rtpadts_ctrl and rtpadts_dp.
//
//   channel   direction  tdata                          tuser       tlast
//   in_       slave      [7:0] packet byte              -           end of packet
//   out_      master     [55:0] ADTS header, [63:56]    is header   last result
//                        payload byte                               of the byte
//   cfg_      APB        asc_word at byte address 0
//
// A byte that gives no result or one payload result is taken as soon as the
// framer is idle. A byte that closes a unit or the AU header area then sends the
// ADTS headers it starts (up to 15); the single output register sets the pace of those headers.
// Reset is synchronous and clears all control state; the size table needs none.
// A stalled output holds one result and blocks the next one that needs a slot.
module rtp_aac_to_adts_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [55:0] header_word, [63:56] payload_byte
  output logic        out_tuser,  // is_header
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rtpadts_pkg::cmd_t cmd;
  rtpadts_pkg::sts_t sts;
  logic [15:0]       asc_r;
  logic              cfg_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asc_r <= rtpadts_pkg::AscReset;
    end else if (cfg_wr && cfg_paddr[2] == rtpadts_pkg::RegAsc) begin
      asc_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == rtpadts_pkg::RegAsc) ? {16'd0, asc_r} : 32'd0;

  rtpadts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtpadts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .in_eop     (in_tlast),
    .asc_word   (asc_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Header results carry the ADTS sync word and trailer, no payload byte
  a_hdr_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[55:40] == 16'hFFF1 && out_tdata[7:0] == 8'hFC && out_tdata[63:56] == 8'h00)
    else $error("malformed ADTS header result");

  // Payload results carry no header bits
  a_pay_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[55:0] == 56'd0)
    else $error("payload result with header bits set");

  // No item is taken while headers are still being sent
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_hdr |-> !in_tready)
    else $error("input accepted during header run");

  // Output is empty after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
